@@ rtl/core/smsr_pkg.sv @@
// Shared types, constants and helpers of the stepwise motor speed regulator.
package smsr_pkg;

  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned TGT_W    = 16;
  localparam int unsigned MEAS_W   = 14;
  localparam int unsigned QUOT_W   = 14;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned HOLD_W   = 4;
  localparam int unsigned SCNT_W   = 8;
  localparam int unsigned FCNT_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Reciprocal of five in 2^-18 units; exact for any 16-bit dividend.
  localparam logic [16:0] DIV5_MUL   = 17'd52429;
  localparam int unsigned DIV5_SHIFT = 18;

  // Reset values of the registers.
  localparam logic [DUTY_W-1:0] START_DUTY_RST      = 16'd2000;
  localparam logic [SCNT_W-1:0] STARTUP_PERIODS_RST = 8'd10;
  localparam logic [FCNT_W-1:0] FAULT_PERIODS_RST   = 16'd30;
  localparam logic [DUTY_W-1:0] PWM_MAX_RST         = 16'hFFFF;

  // Gap thresholds.
  localparam logic [MEAS_W-1:0] GAP_OK    = 14'd20;
  localparam logic [MEAS_W-1:0] GAP_HUGE  = 14'd30;
  localparam logic [MEAS_W-1:0] GAP_LARGE = 14'd10;
  localparam logic [MEAS_W-1:0] GAP_MID   = 14'd5;
  localparam logic [MEAS_W-1:0] GAP_SMALL = 14'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DUTY      = 2'd0,
    REG_STARTUP_PERIODS = 2'd1,
    REG_FAULT_PERIODS   = 2'd2,
    REG_PWM_MAX         = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TGT_W-1:0]  target_rpm;
    logic [MEAS_W-1:0] measured_speed;
  } in_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic              speed_fault;
    logic              in_startup;
  } out_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] start_duty;
    logic [SCNT_W-1:0] startup_periods;
    logic [FCNT_W-1:0] fault_periods;
    logic [DUTY_W-1:0] pwm_max;
  } cfg_t;

  // Registered input beat with the commanded speed already scaled by 1/5.
  typedef struct packed {
    logic [TGT_W-1:0]  target_rpm;
    logic [QUOT_W-1:0] target_div5;
    logic [MEAS_W-1:0] measured_speed;
  } stage_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [HOLD_W-1:0] hold;
  } ladder_t;

  // Step size and hold-off for a gap magnitude; zero step means no move.
  function automatic ladder_t step_ladder(input logic [MEAS_W-1:0] mag);
    ladder_t r;
    r = '0;
    if (mag > GAP_HUGE) begin
      r.step = 8'd200;
      r.hold = 4'd1;
    end else if (mag > GAP_LARGE) begin
      r.step = 8'd100;
      r.hold = 4'd3;
    end else if (mag > GAP_MID) begin
      r.step = 8'd50;
      r.hold = 4'd5;
    end else if (mag > GAP_SMALL) begin
      r.step = 8'd10;
      r.hold = 4'd10;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/smsr_cfg.sv @@
// Configuration register file of the regulator.
module smsr_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [smsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [smsr_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  output smsr_pkg::cfg_t                      cfg_o
);
  import smsr_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_duty      <= START_DUTY_RST;
      cfg_q.startup_periods <= STARTUP_PERIODS_RST;
      cfg_q.fault_periods   <= FAULT_PERIODS_RST;
      cfg_q.pwm_max         <= PWM_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_START_DUTY:      cfg_q.start_duty      <= cfg_data_i;
        REG_STARTUP_PERIODS: cfg_q.startup_periods <= cfg_data_i[SCNT_W-1:0];
        REG_FAULT_PERIODS:   cfg_q.fault_periods   <= cfg_data_i;
        REG_PWM_MAX:         cfg_q.pwm_max         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/smsr_in_stage.sv @@
// Input register of the regulator; scales the commanded speed by 1/5 on capture.
module smsr_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  smsr_pkg::in_beat_t in_data_i,
  input  logic               advance_i,
  output logic               stage_valid_o,
  output smsr_pkg::stage_t   stage_o
);
  import smsr_pkg::*;

  logic        valid_q, valid_d;
  stage_t      stage_q;
  logic        accept;
  logic [32:0] prod;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // target / 5 by reciprocal multiply
  assign prod = 33'(in_data_i.target_rpm) * 33'(DIV5_MUL);

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.target_rpm     <= in_data_i.target_rpm;
      stage_q.target_div5    <= prod[DIV5_SHIFT+QUOT_W-1:DIV5_SHIFT];
      stage_q.measured_speed <= in_data_i.measured_speed;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;

endmodule

@@ rtl/core/smsr_core.sv @@
// Regulator state update and result register.
module smsr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smsr_pkg::cfg_t      cfg_i,
  input  logic                stage_valid_i,
  input  smsr_pkg::stage_t    stage_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smsr_pkg::out_beat_t out_data_o
);
  import smsr_pkg::*;

  logic [TGT_W-1:0]  last_target_q, last_target_d;
  logic              pending_q, pending_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic [HOLD_W-1:0] hold_q, hold_d;
  logic              sactive_q, sactive_d;
  logic [SCNT_W-1:0] scount_q, scount_d;
  logic [FCNT_W-1:0] fcount_q, fcount_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  logic                    fire;
  logic                    kick;
  logic                    pend;
  logic signed [MEAS_W:0]  gap;
  logic [MEAS_W-1:0]       mag;
  ladder_t                 lad;
  logic signed [17:0]      sum;
  logic [FCNT_W-1:0]       fcnt_now;
  logic                    fault;

  assign advance_o = !out_valid_q || !out_stall_i;
  assign fire      = stage_valid_i && advance_o;

  always_comb begin
    last_target_d = last_target_q;
    pending_d     = pending_q;
    duty_d        = duty_q;
    hold_d        = hold_q;
    sactive_d     = sactive_q;
    scount_d      = scount_q;
    fcnt_now      = fcount_q;
    kick          = 1'b0;
    pend          = pending_q;

    gap = $signed({1'b0, stage_i.measured_speed}) - $signed({1'b0, stage_i.target_div5});
    mag = gap[MEAS_W] ? MEAS_W'(-gap) : gap[MEAS_W-1:0];
    lad = step_ladder(mag);
    if (gap[MEAS_W]) begin
      sum = $signed({2'b00, duty_q}) + $signed({10'b0, lad.step});
    end else begin
      sum = $signed({2'b00, duty_q}) - $signed({10'b0, lad.step});
    end

    if (stage_i.target_rpm != last_target_q) begin
      last_target_d = stage_i.target_rpm;
      pend          = 1'b1;
    end
    pending_d = pend;

    // kick in progress
    if (sactive_q) begin
      if (scount_q != '0) begin
        scount_d = scount_q - 1'b1;
        kick     = 1'b1;
      end else begin
        sactive_d = 1'b0;
      end
    end

    // take up a pending command change
    if (!kick && pend) begin
      pending_d = 1'b0;
      if (duty_q < cfg_i.start_duty) begin
        sactive_d = 1'b1;
        scount_d  = cfg_i.startup_periods;
        kick      = 1'b1;
      end
    end

    if (!kick) begin
      if (mag <= GAP_OK) begin
        fcnt_now = cfg_i.fault_periods;
      end
      if (hold_q == '0) begin
        if (lad.step != '0) begin
          hold_d = lad.hold;
          if (sum[17]) begin
            duty_d = '0;
          end else if (sum[16:0] > {1'b0, cfg_i.pwm_max}) begin
            duty_d = cfg_i.pwm_max;
          end else begin
            duty_d = sum[DUTY_W-1:0];
          end
        end
      end else begin
        hold_d = hold_q - 1'b1;
      end
    end

    fault    = (fcnt_now == '0);
    fcount_d = fault ? fcnt_now : fcnt_now - 1'b1;

    out_d.pwm_duty    = kick ? cfg_i.start_duty : duty_d;
    out_d.speed_fault = fault;
    out_d.in_startup  = kick;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (advance_o) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_target_q <= '0;
      pending_q     <= 1'b0;
      duty_q        <= '0;
      hold_q        <= '0;
      sactive_q     <= 1'b0;
      scount_q      <= '0;
      fcount_q      <= FAULT_PERIODS_RST;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        last_target_q <= last_target_d;
        pending_q     <= pending_d;
        duty_q        <= duty_d;
        hold_q        <= hold_d;
        sactive_q     <= sactive_d;
        scount_q      <= scount_d;
        fcount_q      <= fcount_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q <= 4'd10)
    else $error("hold-off counter out of range");

  a_idle_kick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sactive_q |-> scount_q == '0)
    else $error("kick counter nonzero with no kick running");

  a_duty_only_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(duty_q))
    else $error("stored duty moved without an item");

  a_fault_counter_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && out_d.speed_fault |=> fcount_q == '0)
    else $error("fault flagged with fault counter not at zero");

endmodule

@@ rtl/core/stepwise_motor_speed_regulator.sv @@
// An accepted beat passes the input register, then the result register, before it shows on the output.
// Throughput: one beat per cycle unless stalled; the state update is one pass between them.
// The result register frees the input side whenever the output is taken or empty.
// Reset (async, active low) clears valids and state; fault counter loads 30 and
// the registers return to start_duty 2000, startup_periods 10, fault_periods 30, pwm_max 65535.
module stepwise_motor_speed_regulator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  smsr_pkg::in_beat_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output smsr_pkg::out_beat_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [smsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [smsr_pkg::CFG_DAT_W-1:0]      cfg_data_i
);
  import smsr_pkg::*;

  cfg_t   cfg;
  logic   stage_valid;
  stage_t stage;
  logic   advance;

  smsr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  smsr_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  smsr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .advance_o     (advance),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
